// ===== hdl/bss_pkg.sv =====
`timescale 1ns / 1ps

package bss_pkg;

    localparam int SET_CAPACITY_DEF = 64;

    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST    = 3'd2;
    localparam logic [OP_W-1:0] OP_GREATER = 3'd3;
    localparam logic [OP_W-1:0] OP_LESS    = 3'd4;
    localparam logic [OP_W-1:0] OP_CARD    = 3'd5;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic clr_we;   // clear the slot at the address
        logic load;     // capture a new item, reset the scan accumulators
        logic rd_en;    // read the slot at the address
        logic eval;     // fold the slot read last cycle into the accumulators
        logic finish;   // write back and present the result
    } t_dp_cmd;

endpackage

// ===== hdl/bss_ctrl.sv =====
`timescale 1ns / 1ps

module bss_ctrl #(
    parameter int SET_CAPACITY = bss_pkg::SET_CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    output bss_pkg::t_dp_cmd                  o_cmd,
    output logic [$clog2(SET_CAPACITY)-1:0]   o_addr
);
    import bss_pkg::*;

    localparam int AW   = $clog2(SET_CAPACITY);
    localparam int CNTW = $clog2(SET_CAPACITY + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [CNTW-1:0] LAST_SLOT = CNTW'(SET_CAPACITY - 1);
    localparam logic [CNTW-1:0] SCAN_END  = CNTW'(SET_CAPACITY);

    logic [1:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == LAST_SLOT) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read slot k while evaluating slot k-1
                o_cmd.rd_en = (r_cnt != SCAN_END);
                o_cmd.eval  = (r_cnt != '0);
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == SCAN_END) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_addr = r_cnt[AW-1:0];

endmodule

// ===== hdl/bss_datapath.sv =====
`timescale 1ns / 1ps

module bss_datapath #(
    parameter int SET_CAPACITY = bss_pkg::SET_CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bss_pkg::t_dp_cmd                  i_cmd,
    input  logic [$clog2(SET_CAPACITY)-1:0]   i_addr,
    input  logic [bss_pkg::OP_W-1:0]          i_opcode,
    input  logic [bss_pkg::VAL_W-1:0]         i_value,
    output logic                              o_valid,
    output logic                              o_ok,
    output logic                              o_full_reject,
    output logic [bss_pkg::COUNT_W-1:0]       o_count,
    output logic                              o_none_match,
    output logic                              o_all_match
);
    import bss_pkg::*;

    localparam int AW   = $clog2(SET_CAPACITY);
    localparam int CNTW = $clog2(SET_CAPACITY + 1);

    // slot word: valid bit over the element value
    logic [VAL_W:0]  r_mem [SET_CAPACITY];
    logic [VAL_W:0]  r_rd_data;
    logic [AW-1:0]   r_rd_idx;

    logic [OP_W-1:0]  r_op;
    logic [VAL_W-1:0] r_val;
    logic             r_hit;
    logic [AW-1:0]    r_hit_idx;
    logic             r_free_found;
    logic [AW-1:0]    r_free_idx;
    logic [CNTW-1:0]  r_match;
    logic [CNTW-1:0]  r_card;

    logic             r_valid;
    logic             r_ok;
    logic             r_full;
    logic [COUNT_W-1:0] r_count;
    logic             r_none;
    logic             r_all;

    logic             slot_vld;
    logic [VAL_W-1:0] slot_val;
    logic             slot_match;

    logic             do_insert;
    logic             do_remove;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W:0]   wr_data;

    logic             res_ok;
    logic             res_full;
    logic [CNTW-1:0]  res_cnt;
    logic             res_none;
    logic             res_all;
    logic [CNTW+COUNT_W-1:0] res_cnt_ext;

    assign slot_vld = r_rd_data[VAL_W];
    assign slot_val = r_rd_data[VAL_W-1:0];

    always_comb begin
        case (r_op)
            OP_GREATER: slot_match = (slot_val > r_val);
            OP_LESS:    slot_match = (slot_val < r_val);
            default:    slot_match = 1'b0;
        endcase
    end

    assign do_insert = i_cmd.finish && (r_op == OP_INSERT) && !r_hit && r_free_found;
    assign do_remove = i_cmd.finish && (r_op == OP_REMOVE) && r_hit;

    always_comb begin
        wr_en   = i_cmd.clr_we || do_insert || do_remove;
        wr_addr = i_addr;
        wr_data = '0;
        if (do_insert) begin
            wr_addr = r_free_idx;
            wr_data = {1'b1, r_val};
        end else if (do_remove) begin
            wr_addr = r_hit_idx;
            wr_data = {1'b0, r_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_addr];
            r_rd_idx  <= i_addr;
        end
    end

    // scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_opcode;
            r_val        <= i_value;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_match      <= '0;
            r_card       <= '0;
        end else if (i_cmd.eval) begin
            if (slot_vld) begin
                r_card <= r_card + 1'b1;
                if (slot_val == r_val) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
                if (slot_match) begin
                    r_match <= r_match + 1'b1;
                end
            end else if (!r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
        end
    end

    always_comb begin
        res_ok   = 1'b0;
        res_full = 1'b0;
        res_cnt  = '0;
        res_none = 1'b0;
        res_all  = 1'b0;
        case (r_op)
            OP_INSERT: begin
                res_ok   = !r_hit && r_free_found;
                res_full = !r_hit && !r_free_found;
            end
            OP_REMOVE: res_ok = r_hit;
            OP_TEST:   res_ok = r_hit;
            OP_GREATER, OP_LESS: begin
                res_cnt  = r_match;
                res_none = (r_match == '0);
                res_all  = (r_match != '0) && (r_match == r_card);
            end
            OP_CARD:   res_cnt = r_card;
            default: ;
        endcase
    end

    // count port wraps at its own width
    assign res_cnt_ext = {{COUNT_W{1'b0}}, res_cnt};

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_ok    <= res_ok;
            r_full  <= res_full;
            r_count <= res_cnt_ext[COUNT_W-1:0];
            r_none  <= res_none;
            r_all   <= res_all;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_valid       = r_valid;
    assign o_ok          = r_ok;
    assign o_full_reject = r_full;
    assign o_count       = r_count;
    assign o_none_match  = r_none;
    assign o_all_match   = r_all;

endmodule

// ===== hdl/bounded_set_store.sv =====
`timescale 1ns / 1ps

// Set of up to SET_CAPACITY distinct 32-bit values. Issue a request by raising
// start while busy is low; the opcode and value are taken on that edge. Each
// item produces exactly one result, shown on the o_ ports for a single cycle
// with o_valid high; the result cannot be held off, so capture it then. The
// elements sit in one single-port memory that is scanned one slot per cycle,
// so each item runs a scan of every slot and then a write-back step before the
// next can be accepted: the result strobe comes at the end of the write-back,
// and busy drops with it. After reset busy stays high while the memory's valid
// flags are cleared.
module bounded_set_store #(
    parameter int SET_CAPACITY = bss_pkg::SET_CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bss_pkg::OP_W-1:0]      i_opcode,
    input  logic [bss_pkg::VAL_W-1:0]     i_value,
    output logic                          o_valid,
    output logic                          o_ok,
    output logic                          o_full_reject,
    output logic [bss_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_none_match,
    output logic                          o_all_match
);
    import bss_pkg::*;

    localparam int AW = $clog2(SET_CAPACITY);

    t_dp_cmd         cmd;
    logic [AW-1:0]   addr;

    bss_ctrl #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .o_addr  (addr)
    );

    bss_datapath #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_addr        (addr),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_full_reject (o_full_reject),
        .o_count       (o_count),
        .o_none_match  (o_none_match),
        .o_all_match   (o_all_match)
    );

endmodule

// ===== hdl/bss_checker.sv =====
`timescale 1ns / 1ps

module bss_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic                          o_ok,
    input logic                          o_full_reject,
    input logic [bss_pkg::COUNT_W-1:0]   o_count,
    input logic                          o_none_match,
    input logic                          o_all_match
);

    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result strobe is never held
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    // results appear only as busy drops
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result outside end of item");

    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_full_reject) |->
            (!o_ok && o_count == '0 && !o_none_match && !o_all_match))
        else $error("full reject with other fields set");

    a_none_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_none_match) |-> (!o_all_match && o_count == '0 && !o_ok))
        else $error("none match inconsistent");

endmodule

bind bounded_set_store bss_checker u_bss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_ok          (o_ok),
    .o_full_reject (o_full_reject),
    .o_count       (o_count),
    .o_none_match  (o_none_match),
    .o_all_match   (o_all_match)
);
